>>> rtl/core/cpac_pkg.sv
`default_nettype none

package cpac_pkg;

  localparam int MAX_SIZE  = 63;
  localparam int MASK_W    = MAX_SIZE - 1;
  localparam int SIZE_W    = 6;
  localparam int PART_W    = 6;
  localparam int COUNT_W   = 63;
  localparam int VALS      = 2 ** PART_W;

  typedef struct packed {
    logic [MASK_W-1:0] cut_mask;
    logic              start_new;
  } in_req_t;

  typedef struct packed {
    logic               avoids_pattern;
    logic [COUNT_W-1:0] avoid_count;
  } out_res_t;

  // one part leaving the splitter
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [PART_W-1:0] value;
  } part_t;

  // verdict leaving the checker
  typedef struct packed {
    logic valid;
    logic avoids;
  } verdict_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_HOLD
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/cpac_split.sv
`default_nettype none

module cpac_split
  import cpac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic [MASK_W-1:0] mask,
  input  wire logic [SIZE_W-1:0] nbits,
  output part_t                  part
);

  logic [MASK_W-1:0] shreg;
  logic [SIZE_W-1:0] remain;
  logic [PART_W-1:0] run;
  logic              active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (active && (remain == '0)) begin
      active <= 1'b0;
    end
  end

  // mask shifts out LSB first, one cut bit per cycle
  always_ff @(posedge clk) begin
    if (load) begin
      shreg  <= mask;
      remain <= nbits;
      run    <= PART_W'(1);
    end else if (active && (remain != '0)) begin
      shreg  <= {1'b0, shreg[MASK_W-1:1]};
      remain <= remain - SIZE_W'(1);
      run    <= shreg[0] ? PART_W'(1) : run + PART_W'(1);
    end
  end

  always_comb begin
    part.last  = (remain == '0);
    part.valid = active && ((remain == '0) || shreg[0]);
    part.value = run;
  end

endmodule

`default_nettype wire

>>> rtl/core/cpac_check.sv
`default_nettype none

module cpac_check
  import cpac_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   clear,
  input  wire part_t  part,
  output verdict_t    verdict
);

  logic [VALS-1:0]   forbid;
  logic [VALS-1:0]   rng;
  logic [PART_W-1:0] prev;
  logic [PART_W-1:0] pend_lo;
  logic [PART_W-1:0] pend_hi;
  logic              have_prev;
  logic              pend_valid;
  logic              flagged;
  logic              hit;

  // the newest ascent only applies from two parts on, so it waits in pend
  always_comb begin
    for (int k = 0; k < VALS; k++) begin
      rng[k] = pend_valid && (PART_W'(k) > pend_lo) && (PART_W'(k) < pend_hi);
    end
    hit = forbid[part.value] ||
          (pend_valid && (part.value > pend_lo) && (part.value < pend_hi));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      have_prev  <= 1'b0;
      pend_valid <= 1'b0;
      flagged    <= 1'b0;
      forbid     <= '0;
    end else if (part.valid) begin
      forbid     <= forbid | rng;
      pend_valid <= have_prev && (prev < part.value);
      have_prev  <= 1'b1;
      flagged    <= flagged | hit;
    end
  end

  always_ff @(posedge clk) begin
    if (part.valid) begin
      pend_lo <= prev;
      pend_hi <= part.value;
      prev    <= part.value;
    end
  end

  always_ff @(posedge clk) begin
    verdict.avoids <= !(flagged || hit);
    if (rst) begin
      verdict.valid <= 1'b0;
    end else begin
      verdict.valid <= part.valid && part.last && !clear;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/composition_pattern_avoid_counter.sv
`default_nettype none

// Counts compositions of n (composition_size, 1..63; 0 acts as 1) that avoid
// the dashed pattern 13-2. Each request carries a cut mask (bit i = cut after
// cell i+1, bits at or above n-1 ignored) and start_new, which clears the
// running count before the mask is judged. The mask is shifted out one bit a
// cycle; parts are formed on the fly and checked against a 64-bit set of
// values forbidden by earlier ascents. A request's mask is scanned by the
// serial mask shift register; the checker registers its verdict, which then
// goes to the output register. A new request is taken once the result
// has moved into the output register, even while that result still waits
// to be taken; if the output register is still full when a verdict comes,
// the input stays stalled until it drains.
// composition_size may only be written while no request is in flight.
module composition_pattern_avoid_counter
  import cpac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_req_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_res_t               out_data
);

  state_t             state, state_next;
  logic [SIZE_W-1:0]  comp_size;
  logic [SIZE_W-1:0]  nbits;
  logic [COUNT_W-1:0] count;
  logic               start_flag;
  logic               held_ok;
  logic               accept;
  logic               out_free;
  logic               load_out;
  logic               take_verdict;
  part_t              part;
  verdict_t           verdict;

  // composition size register
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_size <= SIZE_W'(1);
    end else if (cfg_wen) begin
      comp_size <= cfg_wdata;
    end
  end

  // number of cut bits to scan: n-1, with size zero treated as one
  assign nbits = (comp_size == '0) ? '0 : comp_size - SIZE_W'(1);

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      start_flag <= in_data.start_new;
    end
  end

  cpac_split u_split (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .mask  (in_data.cut_mask),
    .nbits (nbits),
    .part  (part)
  );

  cpac_check u_check (
    .clk     (clk),
    .rst     (rst),
    .clear   (accept),
    .part    (part),
    .verdict (verdict)
  );

  // sequencer: BUSY while scanning, HOLD when the verdict is in but the
  // output register is still occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    take_verdict = 1'b0;
    load_out     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_BUSY;
      end
      S_BUSY: begin
        if (verdict.valid) begin
          take_verdict = 1'b1;
          if (out_free) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // running count, updated when the verdict arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take_verdict) begin
      count <= (start_flag ? '0 : count) + COUNT_W'(verdict.avoids);
    end
  end

  always_ff @(posedge clk) begin
    if (take_verdict) begin
      held_ok <= verdict.avoids;
    end
  end

  // output register; in BUSY the fresh values are used directly
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == S_BUSY) begin
        out_data.avoids_pattern <= verdict.avoids;
        out_data.avoid_count    <= (start_flag ? '0 : count) + COUNT_W'(verdict.avoids);
      end else begin
        out_data.avoids_pattern <= held_ok;
        out_data.avoid_count    <= count;
      end
    end
  end

`ifndef SYNTHESIS
  a_verdict_busy: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> (state == S_BUSY))
    else $error("verdict outside scan");

  a_part_busy: assert property (@(posedge clk) disable iff (rst)
    part.valid |-> (state == S_BUSY))
    else $error("part emitted while not scanning");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result overwrote a pending output");

  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD) |=> $stable(count))
    else $error("count moved while result held");
`endif

endmodule

`default_nettype wire
